>>> rtl/sacr_pkg.sv
// Package with shared types and constants for the cache replacement unit.
`timescale 1ns / 1ps
package sacr_pkg;
  localparam int LINE_BYTES   = 64;
  localparam int WAYS_PER_SET = 16;
  localparam int SET_COUNT    = 1024;
  localparam int SIG_ENTRIES  = 2048;
  localparam int ADDR_BITS    = 48;

  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int TAG_LSB     = OFFSET_BITS + $clog2(SET_COUNT);
  localparam int TAG_BITS    = ADDR_BITS - TAG_LSB;
  localparam int WAY_BITS    = (WAYS_PER_SET > 1) ? $clog2(WAYS_PER_SET) : 1;
  localparam int SIG_BITS    = $clog2(SIG_ENTRIES);
  localparam int LINE_BITS   = SET_BITS + WAY_BITS;
  localparam int NLINES      = SET_COUNT * WAYS_PER_SET;

  localparam int WAY_CNT_BITS   = WAY_BITS + 1;
  localparam int RRPV_WORD_BITS = 2 * WAYS_PER_SET;
  localparam logic [WAY_CNT_BITS-1:0] LAST_WAY = WAY_CNT_BITS'(WAYS_PER_SET - 1);

  // The clearing pass sweeps the largest of the three memories.
  localparam int CLR_COUNT = (NLINES > SIG_ENTRIES) ? NLINES : SIG_ENTRIES;
  localparam int CLR_BITS  = $clog2(CLR_COUNT + 1);
  localparam logic [CLR_BITS-1:0] CLR_LINE_END = CLR_BITS'(NLINES);
  localparam logic [CLR_BITS-1:0] CLR_SET_END  = CLR_BITS'(SET_COUNT);
  localparam logic [CLR_BITS-1:0] CLR_SIG_END  = CLR_BITS'(SIG_ENTRIES);

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_LFU  = 2'd1;
  localparam logic [1:0] POL_SHIP = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SCAN, ST_CTR_READ, ST_UPDATE, ST_OUT
  } state_t;

  // Per-line record kept in the line memory.
  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic                reused;
    logic [31:0]         use_count;
    logic [47:0]         stamp;
    logic [TAG_BITS-1:0] tag;
    logic [SIG_BITS-1:0] sig;
  } line_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic read;
    logic scan;
    logic cnt_rd;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
  } sts_t;
endpackage

>>> rtl/sacr_ctrl.sv
// Controller state machine of the cache replacement unit.
`timescale 1ns / 1ps
module sacr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sacr_pkg::cmd_t    cmd,
  input  sacr_pkg::sts_t    sts
);
  sacr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacr_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      sacr_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_done) begin
          state_nxt = sacr_pkg::ST_IDLE;
        end
      end
      sacr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sacr_pkg::ST_READ;
        end
      end
      sacr_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = sacr_pkg::ST_SCAN;
      end
      sacr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sacr_pkg::ST_CTR_READ;
        end else begin
          cmd.read = 1'b1;
        end
      end
      sacr_pkg::ST_CTR_READ: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = sacr_pkg::ST_UPDATE;
      end
      sacr_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sacr_pkg::ST_OUT;
      end
      sacr_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = sacr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sacr_pkg::ST_CLEAR;
    endcase
  end
endmodule

>>> rtl/sacr_dp.sv
// Datapath: line, RRPV and signature counter memories, way scan and line update.
`timescale 1ns / 1ps
module sacr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sacr_pkg::cmd_t    cmd,
  output sacr_pkg::sts_t    sts,
  input  logic [1:0]        policy,
  input  logic [47:0]       in_address,
  input  logic              in_is_store,
  input  logic [47:0]       in_program_counter,
  input  logic [47:0]       in_stamp,
  output logic              res_hit,
  output logic              res_evicted,
  output logic [47:0]       res_wb,
  output logic              res_dirty
);
  sacr_pkg::line_t                     lines_mem [sacr_pkg::NLINES];
  logic [sacr_pkg::RRPV_WORD_BITS-1:0] rrpv_mem  [sacr_pkg::SET_COUNT];
  logic [1:0]                          cnt_mem   [sacr_pkg::SIG_ENTRIES];

  // Clearing pass over the memories.
  logic [sacr_pkg::CLR_BITS-1:0] clr_r, clr_nxt;
  logic                          clr_line_go, clr_set_go, clr_sig_go;

  // Item registers.
  logic [sacr_pkg::SET_BITS-1:0] set_r;
  logic [sacr_pkg::TAG_BITS-1:0] tag_r;
  logic [sacr_pkg::SIG_BITS-1:0] sig_r;
  logic [47:0]                   stamp_r;
  logic                          store_r;
  logic                          ship_r, lfu_r;

  // Scan state.
  logic [sacr_pkg::WAY_CNT_BITS-1:0]   rd_way_r, sc_way_r;
  sacr_pkg::line_t                     rd_data_r;
  logic [sacr_pkg::RRPV_WORD_BITS-1:0] rrpv_rd_r;
  logic                                hit_r, free_r;
  logic [sacr_pkg::WAY_BITS-1:0]       hit_way_r, free_way_r, best_way_r, r3_way_r;
  sacr_pkg::line_t                     hit_line_r, best_r, r3_line_r;
  logic [31:0]                         free_cnt_r;
  logic [1:0]                          maxr_r;
  logic [1:0]                          cnt_line_r, cnt_new_r;

  logic                          res_hit_r, res_ev_r, res_dirty_r;
  logic [47:0]                   res_wb_r;

  // Current way and update composition.
  sacr_pkg::line_t                     cur, vic, newl, hitl;
  logic [sacr_pkg::WAY_BITS-1:0]       sw, vic_way, fill_way, wr_way;
  logic [1:0]                          cur_rrpv, age, cnt_fill;
  logic                                way_hit, evict, train_up, train_dn;
  logic [sacr_pkg::SIG_BITS-1:0]       cnt_idx;
  logic [sacr_pkg::RRPV_WORD_BITS-1:0] rrpv_upd;

  // Line address of a way in the current set.
  function automatic logic [sacr_pkg::LINE_BITS-1:0] laddr(
      input logic [sacr_pkg::SET_BITS-1:0] s, input logic [sacr_pkg::WAY_BITS-1:0] w);
    laddr = {s, w};
  endfunction

  assign clr_line_go    = cmd.clear_en && (clr_r < sacr_pkg::CLR_LINE_END);
  assign clr_set_go     = cmd.clear_en && (clr_r < sacr_pkg::CLR_SET_END);
  assign clr_sig_go     = cmd.clear_en && (clr_r < sacr_pkg::CLR_SIG_END);
  assign clr_nxt        = clr_r + 1'b1;
  assign sts.clear_done = cmd.clear_en && !clr_line_go && !clr_sig_go;
  assign sts.scan_done  = (sc_way_r == sacr_pkg::LAST_WAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_r <= clr_nxt;
    end
  end

  // Memory read ports, registered.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data_r <= lines_mem[laddr(set_r, rd_way_r[sacr_pkg::WAY_BITS-1:0])];
      rrpv_rd_r <= rrpv_mem[set_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      cnt_line_r <= cnt_mem[cnt_idx];
      cnt_new_r  <= cnt_mem[sig_r];
    end
  end

  assign cur      = rd_data_r;
  assign sw       = sc_way_r[sacr_pkg::WAY_BITS-1:0];
  assign cur_rrpv = rrpv_rd_r[{sw, 1'b0} +: 2];
  assign way_hit  = cur.valid && (cur.tag == tag_r);

  always_comb begin
    if (ship_r) begin
      vic_way = r3_way_r;
      vic     = r3_line_r;
    end else begin
      vic_way = best_way_r;
      vic     = best_r;
    end
    evict    = !hit_r && !free_r;
    fill_way = free_r ? free_way_r : vic_way;
    wr_way   = hit_r ? hit_way_r : fill_way;
    cnt_idx  = hit_r ? hit_line_r.sig : vic.sig;
    train_up = hit_r && ship_r && (cnt_line_r != 2'd3);
    train_dn = evict && ship_r && !vic.reused && (cnt_line_r != 2'd0);
    // The new line sees the counter after the victim's training.
    cnt_fill = (train_dn && (vic.sig == sig_r)) ? (cnt_line_r - 2'd1) : cnt_new_r;
    age      = 2'd3 - maxr_r;

    newl.valid     = 1'b1;
    newl.dirty     = store_r;
    newl.reused    = 1'b0;
    newl.use_count = evict ? 32'd1 :
                     ((free_cnt_r == 32'hFFFF_FFFF) ? free_cnt_r : free_cnt_r + 32'd1);
    newl.stamp     = stamp_r;
    newl.tag       = tag_r;
    newl.sig       = sig_r;

    hitl       = hit_line_r;
    hitl.stamp = stamp_r;
    if (hit_line_r.use_count != 32'hFFFF_FFFF) begin
      hitl.use_count = hit_line_r.use_count + 32'd1;
    end
    if (ship_r) begin
      hitl.reused = 1'b1;
    end
    if (store_r) begin
      hitl.dirty = 1'b1;
    end

    rrpv_upd = rrpv_rd_r;
    if (ship_r && evict) begin
      for (int w = 0; w < sacr_pkg::WAYS_PER_SET; w++) begin
        rrpv_upd[2*w +: 2] = rrpv_rd_r[2*w +: 2] + age;
      end
    end
    if (hit_r) begin
      if (ship_r) begin
        rrpv_upd[{hit_way_r, 1'b0} +: 2] = 2'd0;
      end
    end else begin
      rrpv_upd[{fill_way, 1'b0} +: 2] = (cnt_fill == 2'd0) ? 2'd3 : 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_line_go) begin
      lines_mem[clr_r[sacr_pkg::LINE_BITS-1:0]] <= '0;
    end else if (cmd.update) begin
      lines_mem[laddr(set_r, wr_way)] <= hit_r ? hitl : newl;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_set_go) begin
      rrpv_mem[clr_r[sacr_pkg::SET_BITS-1:0]] <= '0;
    end else if (cmd.update) begin
      rrpv_mem[set_r] <= rrpv_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_sig_go) begin
      cnt_mem[clr_r[sacr_pkg::SIG_BITS-1:0]] <= 2'd2;
    end else if (cmd.update && train_up) begin
      cnt_mem[hit_line_r.sig] <= cnt_line_r + 2'd1;
    end else if (cmd.update && train_dn) begin
      cnt_mem[vic.sig] <= cnt_line_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_way_r <= '0;
      sc_way_r <= '0;
    end else begin
      if (cmd.load) begin
        rd_way_r <= '0;
        sc_way_r <= '0;
      end
      if (cmd.read) begin
        rd_way_r <= rd_way_r + 1'b1;
      end
      if (cmd.scan && !sts.scan_done) begin
        sc_way_r <= sc_way_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r   <= in_address[sacr_pkg::OFFSET_BITS +: sacr_pkg::SET_BITS];
      tag_r   <= in_address[sacr_pkg::ADDR_BITS-1:sacr_pkg::TAG_LSB];
      sig_r   <= in_program_counter[1 +: sacr_pkg::SIG_BITS];
      stamp_r <= in_stamp;
      store_r <= in_is_store;
      ship_r  <= (policy == sacr_pkg::POL_SHIP);
      lfu_r   <= (policy == sacr_pkg::POL_LFU);
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end
    if (cmd.scan) begin
      if (way_hit && !hit_r) begin
        hit_r      <= 1'b1;
        hit_way_r  <= sw;
        hit_line_r <= cur;
      end
      if (!cur.valid && !free_r) begin
        free_r     <= 1'b1;
        free_way_r <= sw;
        free_cnt_r <= cur.use_count;
      end
      // Lowest stamp or count, the lowest way winning ties.
      if ((sw == '0) || (lfu_r ? (cur.use_count < best_r.use_count)
                               : (cur.stamp < best_r.stamp))) begin
        best_r     <= cur;
        best_way_r <= sw;
      end
      // The first way holding the largest RRPV reaches the distant value after aging.
      if ((sw == '0) || (cur_rrpv > maxr_r)) begin
        maxr_r    <= cur_rrpv;
        r3_way_r  <= sw;
        r3_line_r <= cur;
      end
    end
    if (cmd.update) begin
      res_hit_r   <= hit_r;
      res_ev_r    <= evict;
      res_dirty_r <= evict && vic.dirty;
      res_wb_r    <= evict ? (48'({vic.tag, {sacr_pkg::TAG_LSB{1'b0}}}) |
                              (48'(set_r) << sacr_pkg::OFFSET_BITS)) : 48'd0;
    end
  end

  assign res_hit     = res_hit_r;
  assign res_evicted = res_ev_r;
  assign res_wb      = res_wb_r;
  assign res_dirty   = res_dirty_r;
endmodule

>>> rtl/set_assoc_cache_replacement_unit.sv
// Top level of the set-associative cache replacement unit.
`timescale 1ns / 1ps
//  port group | role   | carries
//  in_        | slave  | tdata: address, program_counter, stamp; tuser: is_store
//  out_       | master | tdata: hit, evicted, writeback_address, victim_dirty
//  cfg_       | slave  | policy register
// An item passes through these steps in order: accepting it, addressing way 0, reading
// the set one way per cycle through the single read port, a counter read, the
// write-back and presenting the result.
// The result is held until out_tready is high; the input stays not ready until the
// result has left. After reset a clearing pass sweeps the memories while the input
// stays not ready.
module set_assoc_cache_replacement_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // address, program_counter, stamp
  input  logic         in_tuser,   // is_store
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // hit, evicted, writeback_address, victim_dirty
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);
  sacr_pkg::cmd_t cmd;
  sacr_pkg::sts_t sts;
  logic [1:0]     policy_r;
  logic           hit, ev, vd;
  logic [47:0]    wb;

  // The policy is sampled when an item is accepted, so a write never disturbs one in flight.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= sacr_pkg::POL_LRU;
    end else if (cfg_valid && cfg_ready) begin
      policy_r <= cfg_data;
    end
  end

  sacr_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd, .sts
  );

  sacr_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .policy(policy_r),
    .in_address(in_tdata[47:0]), .in_is_store(in_tuser),
    .in_program_counter(in_tdata[95:48]), .in_stamp(in_tdata[143:96]),
    .res_hit(hit), .res_evicted(ev), .res_wb(wb), .res_dirty(vd)
  );

  assign out_tdata = {5'd0, vd, wb, ev, hit};
endmodule
